### src/cbp_pkg.sv
// shared types and constants of the cpu burst predictor
package cbp_pkg;

    // field widths
    localparam int TIME_W       = 24;
    localparam int TOTAL_W      = TIME_W + 8;
    localparam int COUNT_W      = 16;
    localparam int ALPHA_W      = 9;
    localparam int ALPHA_SHIFT  = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = TIME_W;

    // alpha of one, Q1.8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_SHIFT);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRED = CFG_IDX_W'(1);

    // input item
    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] burst_time;
    } cbp_in_t;

    // result item
    typedef struct packed {
        logic signed [TIME_W:0] remaining_estimate;
        logic [TIME_W-1:0]      predicted_burst;
        logic [TOTAL_W-1:0]     total_time;
        logic [TOTAL_W-1:0]     mean_burst;
        logic [COUNT_W-1:0]     use_count;
    } cbp_out_t;

endpackage

### src/cpu_burst_predictor_top.sv
// cpu burst predictor: microcoded sequencer with serial divider and weighted average
//
// Each transfer on the s_ channel charges one CPU burst (Q16.8) to the process and
// yields one result on the m_ channel: remaining estimate, exponential-average
// prediction, saturating total time, mean burst (total / count, truncated) and use
// count. A dispatch burst (operation = 1) also sets the prediction to
// (alpha*prediction + (1-alpha)*current burst) rounded, reloads the remaining
// estimate and clears the current burst; alpha above 1.0 acts as 1.0. The block
// works on one item at a time, stepped by a six-entry microcode table: an update
// step, three multiply/round steps on dispatch only, 32 steps of the restoring
// divider for the mean, and an output step. s_ready stays low from an accepted
// transfer until that item's output step, so the block cannot take a new item
// before it is through with the last one; the output step waits while the
// previous result is still untaken. Writing initial_prediction also loads the
// prediction and the remaining estimate; writes to unknown indexes are ignored.
module cpu_burst_predictor_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cbp_pkg::cbp_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cbp_pkg::cbp_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cbp_pkg::*;

    localparam int SUM_W     = ALPHA_W + TIME_W;
    localparam int DIV_CNT_W = $clog2(TOTAL_W);
    localparam int PC_W      = 3;

    // micro-operations and jump conditions
    typedef enum logic [2:0] {
        UOP_UPD,
        UOP_MULA,
        UOP_MULB,
        UOP_RND,
        UOP_DIV,
        UOP_OUT
    } uop_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NOT_DISPATCH,
        COND_DIV_MORE
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    localparam pc_t PC_DIV = pc_t'(4);

    // microcode table
    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            pc_t'(0): w = '{op: UOP_UPD,  cond: COND_NOT_DISPATCH, target: PC_DIV};
            pc_t'(1): w = '{op: UOP_MULA, cond: COND_NONE,         target: pc_t'(0)};
            pc_t'(2): w = '{op: UOP_MULB, cond: COND_NONE,         target: pc_t'(0)};
            pc_t'(3): w = '{op: UOP_RND,  cond: COND_NONE,         target: pc_t'(0)};
            pc_t'(4): w = '{op: UOP_DIV,  cond: COND_DIV_MORE,     target: PC_DIV};
            default:  w = '{op: UOP_OUT,  cond: COND_NONE,         target: pc_t'(0)};
        endcase
        return w;
    endfunction

    // sequencer state
    logic busy_reg;
    pc_t  pc_reg;
    logic m_valid_reg;

    // item and configuration
    logic                   op_reg;
    logic [TIME_W-1:0]      burst_reg;
    logic [ALPHA_W-1:0]     alpha_reg;

    // process state
    logic [TIME_W-1:0]      pred_reg;
    logic [TIME_W:0]        rem_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TIME_W-1:0]      cur_reg;
    logic [COUNT_W-1:0]     count_reg;

    // datapath work registers
    logic [SUM_W-1:0]       prod_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_W-1:0]     div_rem_reg;
    logic [TOTAL_W-1:0]     div_quo_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    cbp_out_t               m_data_reg;

    // combinational datapath
    ctrl_t                  ctrl;
    logic                   cond_true;
    logic                   step_go;
    logic [ALPHA_W-1:0]     a_eff;
    logic [ALPHA_W-1:0]     a_inv;
    logic [TIME_W+1:0]      rem_diff;
    logic [TIME_W:0]        rem_next;
    logic [TOTAL_W:0]       total_sum;
    logic [TOTAL_W-1:0]     total_next;
    logic [TIME_W:0]        cur_sum;
    logic [TIME_W-1:0]      cur_next;
    logic [COUNT_W-1:0]     count_next;
    logic [SUM_W:0]         rnd_sum;
    logic [TIME_W-1:0]      pred_next;
    logic [COUNT_W:0]       div_shift;
    logic                   div_ge;
    logic [COUNT_W:0]       div_sub;

    assign ctrl = ucode_rom(pc_reg);

    // jump condition and output stall
    always_comb begin
        unique case (ctrl.cond)
            COND_NOT_DISPATCH: cond_true = !op_reg;
            COND_DIV_MORE:     cond_true = (div_cnt_reg != '0);
            default:           cond_true = 1'b0;
        endcase
        step_go = busy_reg && !((ctrl.op == UOP_OUT) && m_valid_reg && !m_ready);
    end

    // alpha clamped to one
    assign a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign a_inv = ALPHA_ONE - a_eff;

    // charge the burst, saturating
    always_comb begin
        rem_diff   = {rem_reg[TIME_W], rem_reg} - {2'b00, burst_reg};
        rem_next   = (rem_diff[TIME_W+1] != rem_diff[TIME_W]) ?
                     {1'b1, {TIME_W{1'b0}}} : rem_diff[TIME_W:0];
        total_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(burst_reg);
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        cur_sum    = {1'b0, cur_reg} + {1'b0, burst_reg};
        cur_next   = cur_sum[TIME_W] ? '1 : cur_sum[TIME_W-1:0];
        count_next = (&count_reg) ? count_reg : count_reg + COUNT_W'(1);
    end

    // round half up and clamp the weighted average
    always_comb begin
        rnd_sum   = {1'b0, sum_reg} + (SUM_W+1)'(ALPHA_ONE >> 1);
        pred_next = (|rnd_sum[SUM_W:TIME_W+ALPHA_SHIFT]) ?
                    '1 : rnd_sum[TIME_W+ALPHA_SHIFT-1:ALPHA_SHIFT];
    end

    // one restoring divider step
    always_comb begin
        div_shift = {div_rem_reg, div_quo_reg[TOTAL_W-1]};
        div_ge    = (div_shift >= {1'b0, count_reg});
        div_sub   = div_shift - {1'b0, count_reg};
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (step_go && (ctrl.op == UOP_OUT)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_valid && s_ready) begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end else if (step_go) begin
                if (ctrl.op == UOP_OUT) begin
                    busy_reg <= 1'b0;
                end
                pc_reg <= cond_true ? ctrl.target : pc_reg + pc_t'(1);
            end
        end
    end

    // configuration and process state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= ALPHA_W'(128);
            pred_reg      <= '0;
            rem_reg       <= '0;
            total_reg     <= '0;
            cur_reg       <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ALPHA: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    CFG_INIT_PRED: begin
                        pred_reg      <= cfg_wdata[TIME_W-1:0];
                        rem_reg       <= {1'b0, cfg_wdata[TIME_W-1:0]};
                    end
                    default: ;
                endcase
            end
            if (step_go) begin
                unique case (ctrl.op)
                    UOP_UPD: begin
                        rem_reg   <= rem_next;
                        total_reg <= total_next;
                        cur_reg   <= cur_next;
                        count_reg <= count_next;
                    end
                    UOP_RND: begin
                        pred_reg <= pred_next;
                        rem_reg  <= {1'b0, pred_next};
                        cur_reg  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // item capture and datapath work registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_data.operation;
            burst_reg <= s_data.burst_time;
        end
        if (step_go) begin
            unique case (ctrl.op)
                UOP_UPD: begin
                    div_quo_reg <= total_next;
                    div_rem_reg <= '0;
                    div_cnt_reg <= DIV_CNT_W'(TOTAL_W - 1);
                end
                UOP_MULA: prod_reg <= SUM_W'(a_eff) * SUM_W'(pred_reg);
                UOP_MULB: sum_reg  <= prod_reg + SUM_W'(a_inv) * SUM_W'(cur_reg);
                UOP_DIV: begin
                    div_rem_reg <= div_ge ? div_sub[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
                    div_quo_reg <= {div_quo_reg[TOTAL_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                end
                UOP_OUT: begin
                    m_data_reg.remaining_estimate <= rem_reg;
                    m_data_reg.predicted_burst    <= pred_reg;
                    m_data_reg.total_time         <= total_reg;
                    m_data_reg.mean_burst         <= div_quo_reg;
                    m_data_reg.use_count          <= count_reg;
                end
                default: ;
            endcase
        end
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a transfer starts a program, so the input closes at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after an accepted transfer");

    // a result appears only from the output step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(busy_reg && (ctrl.op == UOP_OUT)))
        else $error("result raised outside the output step");

    // every result has charged at least one burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.use_count != '0))
        else $error("result with zero use count");

    // the mean never exceeds the total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.mean_burst <= m_data.total_time))
        else $error("mean burst above total time");

endmodule

### dv/tb.sv
// testbench of the cpu burst predictor: directed and random bursts checked against a predictor
`timescale 1ns / 100ps

module tb;
    import cbp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int SETTLE      = 40;

    // burst kinds
    localparam logic OP_INTERRUPT = 1'b0;
    localparam logic OP_DISPATCH  = 1'b1;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // burst accounting and expected results of the process
    class burst_ledger;
        logic [ALPHA_W-1:0] weight;
        logic [TIME_W-1:0]  prediction;
        logic [TIME_W-1:0]  burst_acc;
        longint             left_est;
        logic [TOTAL_W-1:0] total_cpu;
        logic [TOTAL_W-1:0] mean_cpu;
        logic [COUNT_W-1:0] charges;
        cbp_out_t           predicted_results[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            weight       = ALPHA_ONE >> 1;
            prediction   = '0;
            left_est     = 0;
            burst_acc    = '0;
            total_cpu    = '0;
            mean_cpu     = '0;
            charges      = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ALPHA: begin
                    weight = value[ALPHA_W-1:0];
                end
                CFG_INIT_PRED: begin
                    prediction = value[TIME_W-1:0];
                    left_est   = longint'(value[TIME_W-1:0]);
                end
                default: begin
                end
            endcase
        endfunction

        // charge one burst and queue the result it must produce
        function void charge_burst(cbp_in_t item);
            longint unsigned a;
            longint unsigned acc;
            longint unsigned sum;
            longint          floor_est;
            cbp_out_t        res;
            a         = (weight > ALPHA_ONE) ? ALPHA_ONE : weight;
            floor_est = -(longint'(1) << TIME_W);

            left_est = left_est - longint'(item.burst_time);
            if (left_est < floor_est) begin
                left_est = floor_est;
            end
            acc       = total_cpu + item.burst_time;
            total_cpu = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
            acc       = burst_acc + item.burst_time;
            burst_acc = (acc > TIME_MAX) ? TIME_MAX : acc[TIME_W-1:0];
            if (charges != COUNT_MAX) begin
                charges++;
            end
            mean_cpu = total_cpu / charges;

            // dispatch folds the finished burst into the prediction
            if (item.operation == OP_DISPATCH) begin
                sum = a * prediction + (ALPHA_ONE - a) * burst_acc;
                sum = (sum + (ALPHA_ONE >> 1)) >> ALPHA_SHIFT;
                if (sum > TIME_MAX) begin
                    sum = TIME_MAX;
                end
                prediction = sum[TIME_W-1:0];
                left_est   = longint'(sum);
                burst_acc  = '0;
            end

            res.remaining_estimate = left_est[TIME_W:0];
            res.predicted_burst    = prediction;
            res.total_time         = total_cpu;
            res.mean_burst         = mean_cpu;
            res.use_count          = charges;
            predicted_results.push_back(res);
        endfunction

        function void check_result(cbp_out_t got);
            cbp_out_t exp;
            results_seen++;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                exp = predicted_results.pop_front();
                if (got.remaining_estimate !== exp.remaining_estimate ||
                    got.predicted_burst !== exp.predicted_burst ||
                    got.total_time !== exp.total_time ||
                    got.mean_burst !== exp.mean_burst ||
                    got.use_count !== exp.use_count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch (remaining predicted total mean count)",
                                 results_seen);
                        $display("  expected %0d %h %h %h %h", exp.remaining_estimate,
                                 exp.predicted_burst, exp.total_time, exp.mean_burst,
                                 exp.use_count);
                        $display("  actual   %0d %h %h %h %h", got.remaining_estimate,
                                 got.predicted_burst, got.total_time, got.mean_burst,
                                 got.use_count);
                    end
                end
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    cbp_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    cbp_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit          calm   = 1'b0;
    int          cycles = 0;
    burst_ledger ledger = new();

    cpu_burst_predictor_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int unsigned stall_len;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(99) < 19) begin
                m_ready   <= 1'b0;
                stall_len = $urandom_range(1, 3);
                repeat (stall_len - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_result(m_data);
        end
    end

    // present one burst, returns at the edge that takes it
    task automatic send_burst(logic op, logic [TIME_W-1:0] burst);
        cbp_in_t     item;
        int unsigned gap;
        item.operation  = op;
        item.burst_time = burst;
        if (!calm && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 50);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        ledger.charge_burst(item);
    endtask

    // drop valid and wait until every result is back and the block takes input
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (ledger.predicted_results.size() != 0 || !s_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        ledger.write_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly short bursts, some full range, some near the top; heavy picks mostly near-top and full-range bursts
    function automatic logic [TIME_W-1:0] pick_burst(bit heavy);
        int unsigned r;
        r = $urandom_range(99);
        if (r < (heavy ? 10 : 55)) begin
            return TIME_W'($urandom_range(0, 4095));
        end else if (r < (heavy ? 40 : 80)) begin
            return TIME_W'($urandom);
        end else if (r < 90) begin
            return TIME_MAX - TIME_W'($urandom_range(0, 255));
        end else if ($urandom_range(1) == 1) begin
            return '0;
        end else begin
            return TIME_W'(1) << $urandom_range(TIME_W - 1);
        end
    endfunction

    initial begin
        logic [ALPHA_W-1:0] alpha_set;
        logic [TIME_W-1:0]  init_set;
        int unsigned        run_len;
        logic               op;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // remaining estimate floor and current burst saturation, then an even average
        send_burst(OP_INTERRUPT, '0);
        send_burst(OP_INTERRUPT, TIME_MAX);
        send_burst(OP_INTERRUPT, TIME_MAX);
        send_burst(OP_DISPATCH, '0);

        // alpha of zero takes the burst alone
        wait_idle();
        write_reg(CFG_ALPHA, '0);
        send_burst(OP_DISPATCH, TIME_W'(24'h000100));

        // alpha above one keeps the old prediction, upper data bits ignored
        wait_idle();
        write_reg(CFG_ALPHA, '1);
        send_burst(OP_INTERRUPT, TIME_W'(5));
        send_burst(OP_DISPATCH, TIME_W'(7));

        // rounding below half and exactly half
        wait_idle();
        write_reg(CFG_ALPHA, CFG_DATA_W'(1));
        write_reg(CFG_INIT_PRED, CFG_DATA_W'(1));
        send_burst(OP_DISPATCH, '0);
        wait_idle();
        write_reg(CFG_ALPHA, CFG_DATA_W'(ALPHA_ONE >> 1));
        write_reg(CFG_INIT_PRED, CFG_DATA_W'(1));
        send_burst(OP_DISPATCH, '0);

        // largest average stays in range
        wait_idle();
        write_reg(CFG_ALPHA, CFG_DATA_W'(ALPHA_ONE - 1));
        write_reg(CFG_INIT_PRED, TIME_MAX);
        send_burst(OP_DISPATCH, TIME_MAX);

        // writes to unknown indexes change nothing
        wait_idle();
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        send_burst(OP_INTERRUPT, TIME_W'(1));
        send_burst(OP_DISPATCH, TIME_W'(24'h800000));

        // random phases: runs of interrupted bursts closed by a dispatch
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    alpha_set = '0;
                    init_set  = TIME_MAX;
                end
                1: begin
                    alpha_set = ALPHA_ONE;
                    init_set  = '0;
                end
                2: begin
                    alpha_set = '1;
                    init_set  = TIME_W'($urandom);
                end
                3: begin
                    alpha_set = ALPHA_W'(1);
                    init_set  = TIME_W'(1);
                end
                default: begin
                    alpha_set = ALPHA_W'($urandom_range(0, 300));
                    init_set  = TIME_W'($urandom);
                end
            endcase
            write_reg(CFG_ALPHA, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'('1 << ALPHA_W) >> 0)
                      & ~CFG_DATA_W'({ALPHA_W{1'b1}}) | CFG_DATA_W'(alpha_set));
            write_reg(CFG_INIT_PRED, init_set);
            calm    = (ph == 3);
            run_len = $urandom_range(0, 6);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(99) < 10) begin
                    op = ($urandom_range(1) == 1) ? OP_DISPATCH : OP_INTERRUPT;
                end else if (run_len == 0) begin
                    op      = OP_DISPATCH;
                    run_len = $urandom_range(0, 6);
                end else begin
                    op = OP_INTERRUPT;
                    run_len--;
                end
                send_burst(op, pick_burst(ph == RAND_PHASES - 1));
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### cpu_burst_predictor_top.f
src/cbp_pkg.sv
src/cpu_burst_predictor_top.sv
dv/tb.sv
